// File: src/slle_pkg.sv
package slle_pkg;

  localparam int CELLS  = 64;
  localparam int AW     = $clog2(CELLS);
  localparam int DW     = 32;
  localparam int HEAD   = CELLS - 1;
  localparam int CAP    = CELLS - 2;
  localparam int POS_W  = 6;
  localparam int CELL_W = 6;
  localparam int LEN_W  = 6;
  localparam int CMPW   = ((AW > POS_W) ? AW : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_GET      = 3'd1,
    OP_LOCATE   = 3'd2,
    OP_PRIOR    = 3'd3,
    OP_NEXT     = 3'd4,
    OP_INSERT   = 3'd5,
    OP_DELETE   = 3'd6,
    OP_TRAVERSE = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  typedef enum logic [2:0] {
    A_CUR   = 3'd0,
    A_ZERO  = 3'd1,
    A_HEAD  = 3'd2,
    A_NEW   = 3'd3,
    A_LINKQ = 3'd4
  } addr_sel_t;

  typedef enum logic [1:0] {
    W_LINKQ = 2'd0,
    W_NEW   = 2'd1,
    W_TMP   = 2'd2,
    W_ZERO  = 2'd3
  } wd_sel_t;

  typedef enum logic [1:0] {
    T_POS   = 2'd0,
    T_POSM1 = 2'd1,
    T_CNT   = 2'd2
  } tgt_sel_t;

  typedef enum logic [1:0] {
    V_ZERO  = 2'd0,
    V_DATAQ = 2'd1,
    V_HOLD  = 2'd2
  } vsel_t;

  typedef enum logic {
    C_HEAD  = 1'b0,
    C_LINKQ = 1'b1
  } cur_sel_t;

  typedef struct packed {
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    addr_sel_t wr_sel;
    wd_sel_t   wd_sel;
    logic      dwr_en;
    logic      ld_in;
    logic      ld_tmp;
    logic      ld_new;
    logic      ld_cur;
    cur_sel_t  cur_sel;
    logic      n_clr;
    logic      n_inc;
    logic      ld_tgt;
    tgt_sel_t  tgt_sel;
    logic      ld_hold;
    logic      set_found;
    logic      clr_found;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      res_ld;
    st_t       res_st;
    vsel_t     res_vsel;
    logic      res_cell;
    logic      res_last;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    op_t  cmd;
    logic empty;
    logic get_ok;
    logic ins_ok;
    logic walk_done;
    logic at_end;
    logic eq;
    logic first;
    logic found;
    logic res_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: src/slle_ram.sv
module slle_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] ra,
  output logic [W-1:0]         rq
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rq_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rq_r <= mem[ra];
    end
  end

  assign rq = rq_r;

endmodule

// File: src/slle_dp.sv
module slle_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slle_pkg::dp_cmd_t            c,
  output slle_pkg::dp_sts_t            s,
  input  logic [2:0]                   in_cmd,
  input  logic [slle_pkg::POS_W-1:0]   in_pos,
  input  logic [slle_pkg::DW-1:0]      in_val,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [slle_pkg::DW-1:0]      out_value,
  output logic [slle_pkg::CELL_W-1:0]  out_cell,
  output logic [slle_pkg::LEN_W-1:0]   out_length,
  output logic                         out_empty,
  output logic                         out_last
);
  import slle_pkg::*;

  op_t              cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [DW-1:0]    val_r;
  logic [AW-1:0]    tmp_r, new_r, cur_r, n_r, tgt_r, cnt_r;
  logic [DW-1:0]    hold_r;
  logic             found_r;
  logic [CELLS-1:0] lv_r;
  logic [AW-1:0]    ra_q_r;
  logic             hit_r;
  st_t              res_st_r;
  logic [DW-1:0]    res_val_r;
  logic [CELL_W-1:0] res_cell_r;
  logic             res_last_r;
  logic             out_valid_r;
  st_t              out_st_r;
  logic [DW-1:0]    out_val_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [LEN_W-1:0] out_len_r;
  logic             out_empty_r;
  logic             out_last_r;

  logic [AW-1:0]    ra, wa, wd, lram_q, rstv, link_q;
  logic [DW-1:0]    data_q, res_val_nxt;

  always_comb begin
    case (c.rd_sel)
      A_CUR:   ra = cur_r;
      A_ZERO:  ra = '0;
      A_HEAD:  ra = AW'(HEAD);
      A_NEW:   ra = new_r;
      A_LINKQ: ra = link_q;
      default: ra = '0;
    endcase
    case (c.wr_sel)
      A_CUR:   wa = cur_r;
      A_ZERO:  wa = '0;
      A_HEAD:  wa = AW'(HEAD);
      A_NEW:   wa = new_r;
      default: wa = link_q;
    endcase
    case (c.wd_sel)
      W_LINKQ: wd = link_q;
      W_NEW:   wd = new_r;
      W_TMP:   wd = tmp_r;
      default: wd = '0;
    endcase
    case (c.res_vsel)
      V_DATAQ: res_val_nxt = data_q;
      V_HOLD:  res_val_nxt = hold_r;
      default: res_val_nxt = '0;
    endcase
  end

  slle_ram #(.W(AW), .D(CELLS)) u_link (
    .clk(clk), .we(c.wr_en), .wa(wa), .wd(wd),
    .re(c.rd_en), .ra(ra), .rq(lram_q)
  );

  slle_ram #(.W(DW), .D(CELLS)) u_data (
    .clk(clk), .we(c.dwr_en), .wa(new_r), .wd(val_r),
    .re(c.rd_en), .ra(ra), .rq(data_q)
  );

  // A link cell never written still holds its reset value from the free chain.
  assign rstv   = (ra_q_r < AW'(CAP)) ? ra_q_r + AW'(1) : '0;
  assign link_q = hit_r ? lram_q : rstv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lv_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (c.wr_en) begin
        lv_r[wa] <= 1'b1;
      end
      if (c.cnt_clr) begin
        cnt_r <= '0;
      end else if (c.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end else if (c.cnt_dec) begin
        cnt_r <= cnt_r - AW'(1);
      end
      if (c.clr_found) begin
        found_r <= 1'b0;
      end else if (c.set_found) begin
        found_r <= 1'b1;
      end
      if (c.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c.ld_in) begin
      cmd_r <= op_t'(in_cmd);
      pos_r <= in_pos;
      val_r <= in_val;
    end
    if (c.rd_en) begin
      ra_q_r <= ra;
      hit_r  <= lv_r[ra];
    end
    if (c.ld_tmp) begin
      tmp_r <= link_q;
    end
    if (c.ld_new) begin
      new_r <= link_q;
    end
    if (c.ld_cur) begin
      cur_r <= (c.cur_sel == C_LINKQ) ? link_q : AW'(HEAD);
    end
    if (c.n_clr) begin
      n_r <= '0;
    end else if (c.n_inc) begin
      n_r <= n_r + AW'(1);
    end
    if (c.ld_tgt) begin
      case (c.tgt_sel)
        T_POS:   tgt_r <= AW'(pos_r);
        T_POSM1: tgt_r <= AW'(pos_r - POS_W'(1));
        default: tgt_r <= cnt_r;
      endcase
    end
    if (c.ld_hold) begin
      hold_r <= data_q;
    end
    if (c.res_ld) begin
      res_st_r   <= c.res_st;
      res_val_r  <= res_val_nxt;
      res_cell_r <= c.res_cell ? CELL_W'(cur_r) : '0;
      res_last_r <= c.res_last;
    end
    if (c.emit) begin
      out_st_r    <= res_st_r;
      out_val_r   <= res_val_r;
      out_cell_r  <= res_cell_r;
      out_len_r   <= LEN_W'(cnt_r);
      out_empty_r <= (cnt_r == '0);
      out_last_r  <= res_last_r;
    end
  end

  always_comb begin
    s.cmd       = cmd_r;
    s.empty     = (cnt_r == '0);
    s.get_ok    = (pos_r != '0) && (CMPW'(pos_r) <= CMPW'(cnt_r));
    s.ins_ok    = (pos_r != '0) && (CMPW'(pos_r) <= CMPW'(cnt_r) + CMPW'(1))
                  && (CMPW'(cnt_r) < CMPW'(CAP));
    s.walk_done = (n_r == tgt_r);
    s.at_end    = (n_r == cnt_r);
    s.eq        = (data_q == val_r);
    s.first     = (n_r == AW'(1));
    s.found     = found_r;
    s.res_last  = res_last_r;
    s.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_value  = out_val_r;
  assign out_cell   = out_cell_r;
  assign out_length = out_len_r;
  assign out_empty  = out_empty_r;
  assign out_last   = out_last_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(cnt_r) <= CMPW'(CAP))
    else $error("Element count exceeds the store capacity.");

  a_rw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !(c.wr_en && c.rd_en && (wa == ra)))
    else $error("Link store read and written at one address in one cycle.");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    c.emit |-> (!out_valid_r || out_ready))
    else $error("Result loaded over one not yet taken.");

endmodule

// File: src/slle_ctrl.sv
module slle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slle_pkg::dp_sts_t s,
  output slle_pkg::dp_cmd_t c
);
  import slle_pkg::*;

  typedef enum logic [25:0] {
    S_IDLE = 26'b1 << 0,
    S_DISP = 26'b1 << 1,
    S_WALK = 26'b1 << 2,
    S_WWT  = 26'b1 << 3,
    S_EMIT = 26'b1 << 4,
    S_CL1  = 26'b1 << 5,
    S_CL2  = 26'b1 << 6,
    S_CL3  = 26'b1 << 7,
    S_CL4  = 26'b1 << 8,
    S_CL5  = 26'b1 << 9,
    S_IN1  = 26'b1 << 10,
    S_IN2  = 26'b1 << 11,
    S_IN4  = 26'b1 << 12,
    S_IN5  = 26'b1 << 13,
    S_IN6  = 26'b1 << 14,
    S_DL1  = 26'b1 << 15,
    S_DL2  = 26'b1 << 16,
    S_DL3  = 26'b1 << 17,
    S_DL4  = 26'b1 << 18,
    S_DL5  = 26'b1 << 19,
    S_DL6  = 26'b1 << 20,
    S_GT1  = 26'b1 << 21,
    S_GT2  = 26'b1 << 22,
    S_SC0  = 26'b1 << 23,
    S_SRD  = 26'b1 << 24,
    S_SEV  = 26'b1 << 25
  } state_t;

  state_t state_r, state_nxt;

  function automatic dp_cmd_t f_res(dp_cmd_t ci, st_t st, vsel_t v, logic cell_en,
                                    logic lst);
    dp_cmd_t co;
    co          = ci;
    co.res_ld   = 1'b1;
    co.res_st   = st;
    co.res_vsel = v;
    co.res_cell = cell_en;
    co.res_last = lst;
    return co;
  endfunction

  function automatic dp_cmd_t f_walk(dp_cmd_t ci, tgt_sel_t t);
    dp_cmd_t co;
    co         = ci;
    co.ld_cur  = 1'b1;
    co.cur_sel = C_HEAD;
    co.n_clr   = 1'b1;
    co.ld_tgt  = 1'b1;
    co.tgt_sel = t;
    return co;
  endfunction

  function automatic dp_cmd_t f_rd(dp_cmd_t ci, addr_sel_t a);
    dp_cmd_t co;
    co        = ci;
    co.rd_en  = 1'b1;
    co.rd_sel = a;
    return co;
  endfunction

  function automatic dp_cmd_t f_wr(dp_cmd_t ci, addr_sel_t a, wd_sel_t d);
    dp_cmd_t co;
    co        = ci;
    co.wr_en  = 1'b1;
    co.wr_sel = a;
    co.wd_sel = d;
    return co;
  endfunction

  always_comb begin
    c         = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          c.ld_in   = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (s.cmd)
          OP_CLEAR: begin
            if (s.empty) begin
              c = f_res(c, ST_OK, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              c = f_rd(c, A_ZERO);
              state_nxt = S_CL1;
            end
          end
          OP_GET: begin
            if (!s.get_ok) begin
              c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              c = f_walk(c, T_POS);
              state_nxt = S_WALK;
            end
          end
          OP_INSERT: begin
            if (!s.ins_ok) begin
              c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              c = f_rd(c, A_ZERO);
              state_nxt = S_IN1;
            end
          end
          OP_DELETE: begin
            if (!s.get_ok) begin
              c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              c = f_walk(c, T_POSM1);
              state_nxt = S_WALK;
            end
          end
          default: begin
            if (s.empty) begin
              if (s.cmd == OP_TRAVERSE) begin
                c = f_res(c, ST_EMPTY, V_ZERO, 1'b0, 1'b1);
              end else if (s.cmd == OP_LOCATE) begin
                c = f_res(c, ST_OK, V_ZERO, 1'b0, 1'b1);
              end else begin
                c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              end
              state_nxt = S_EMIT;
            end else begin
              c = f_rd(c, A_HEAD);
              state_nxt = S_SC0;
            end
          end
        endcase
      end
      S_WALK: begin
        if (s.walk_done) begin
          case (s.cmd)
            OP_GET:    state_nxt = S_GT1;
            OP_INSERT: state_nxt = S_IN4;
            OP_DELETE: state_nxt = S_DL1;
            default:   state_nxt = S_CL3;
          endcase
        end else begin
          c = f_rd(c, A_CUR);
          c.n_inc   = 1'b1;
          state_nxt = S_WWT;
        end
      end
      S_WWT: begin
        c.ld_cur  = 1'b1;
        c.cur_sel = C_LINKQ;
        state_nxt = S_WALK;
      end
      S_CL1: begin
        c.ld_tmp  = 1'b1;
        c = f_rd(c, A_HEAD);
        state_nxt = S_CL2;
      end
      S_CL2: begin
        c.ld_new  = 1'b1;
        c = f_walk(c, T_CNT);
        state_nxt = S_WALK;
      end
      S_CL3: begin
        c = f_wr(c, A_CUR, W_TMP);
        state_nxt = S_CL4;
      end
      S_CL4: begin
        c = f_wr(c, A_ZERO, W_NEW);
        state_nxt = S_CL5;
      end
      S_CL5: begin
        c = f_wr(c, A_HEAD, W_ZERO);
        c.cnt_clr = 1'b1;
        c = f_res(c, ST_OK, V_ZERO, 1'b0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_IN1: begin
        c.ld_new  = 1'b1;
        c = f_rd(c, A_LINKQ);
        state_nxt = S_IN2;
      end
      S_IN2: begin
        c = f_wr(c, A_ZERO, W_LINKQ);
        c.dwr_en  = 1'b1;
        c = f_walk(c, T_POSM1);
        state_nxt = S_WALK;
      end
      S_IN4: begin
        c = f_rd(c, A_CUR);
        state_nxt = S_IN5;
      end
      S_IN5: begin
        c = f_wr(c, A_NEW, W_LINKQ);
        state_nxt = S_IN6;
      end
      S_IN6: begin
        c = f_wr(c, A_CUR, W_NEW);
        c.cnt_inc = 1'b1;
        c = f_res(c, ST_OK, V_ZERO, 1'b0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_DL1: begin
        c = f_rd(c, A_CUR);
        state_nxt = S_DL2;
      end
      S_DL2: begin
        c.ld_new  = 1'b1;
        c = f_rd(c, A_LINKQ);
        state_nxt = S_DL3;
      end
      S_DL3: begin
        c = f_wr(c, A_CUR, W_LINKQ);
        c.ld_hold = 1'b1;
        state_nxt = S_DL4;
      end
      S_DL4: begin
        c = f_rd(c, A_ZERO);
        state_nxt = S_DL5;
      end
      S_DL5: begin
        c = f_wr(c, A_NEW, W_LINKQ);
        state_nxt = S_DL6;
      end
      S_DL6: begin
        c = f_wr(c, A_ZERO, W_NEW);
        c.cnt_dec = 1'b1;
        c = f_res(c, ST_OK, V_HOLD, 1'b0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_GT1: begin
        c = f_rd(c, A_CUR);
        state_nxt = S_GT2;
      end
      S_GT2: begin
        c = f_res(c, ST_OK, V_DATAQ, 1'b0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_SC0: begin
        c.ld_cur    = 1'b1;
        c.cur_sel   = C_LINKQ;
        c.n_clr     = 1'b1;
        c.clr_found = 1'b1;
        state_nxt   = S_SRD;
      end
      S_SRD: begin
        c = f_rd(c, A_CUR);
        c.n_inc   = 1'b1;
        state_nxt = S_SEV;
      end
      S_SEV: begin
        c.ld_cur  = 1'b1;
        c.cur_sel = C_LINKQ;
        state_nxt = S_SRD;
        case (s.cmd)
          OP_LOCATE: begin
            if (s.eq) begin
              c.ld_cur  = 1'b0;
              c = f_res(c, ST_OK, V_ZERO, 1'b1, 1'b1);
              state_nxt = S_EMIT;
            end else if (s.at_end) begin
              c = f_res(c, ST_OK, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end
          end
          OP_PRIOR: begin
            if (s.eq && !s.first) begin
              c = f_res(c, ST_OK, V_HOLD, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else if (s.at_end) begin
              c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              c.ld_hold = 1'b1;
            end
          end
          OP_NEXT: begin
            if (s.found) begin
              c = f_res(c, ST_OK, V_DATAQ, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else if (s.at_end) begin
              c = f_res(c, ST_ERR, V_ZERO, 1'b0, 1'b1);
              state_nxt = S_EMIT;
            end else if (s.eq) begin
              c.set_found = 1'b1;
            end
          end
          default: begin
            c = f_res(c, ST_OK, V_DATAQ, 1'b0, s.at_end);
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        if (s.out_free) begin
          c.emit = 1'b1;
          if (s.cmd == OP_TRAVERSE && !s.res_last) begin
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/static_linked_list_engine.sv
// One command request is taken at a time, only while the engine is idle; the
// result register lets the next request in while the last result still waits.
// Each cell visited takes a link memory read with registered data, then
// following the link. Traverse gives one result per element, or one empty
// status for an empty list. The link store comes out of reset as the full free
// chain at once, held by per-cell valid bits, so no clearing pass is needed.
module static_linked_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero pad
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value_out[31:0], cell_index[37:32],
                                  // length[43:38], is_empty[44], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);
  import slle_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [DW-1:0]     o_val;
  logic [CELL_W-1:0] o_cell;
  logic [LEN_W-1:0]  o_len;
  logic              o_empty;

  slle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .s(sts), .c(cmd)
  );

  slle_dp u_dp (
    .clk(clk), .rst_n(rst_n), .c(cmd), .s(sts),
    .in_cmd(in_tuser), .in_pos(in_tdata[5:0]), .in_val(in_tdata[37:6]),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_status(out_tuser),
    .out_value(o_val), .out_cell(o_cell), .out_length(o_len),
    .out_empty(o_empty), .out_last(out_tlast)
  );

  assign out_tdata = {3'b000, o_empty, o_len, o_cell, o_val};

endmodule
